>>> src/z85_pkg.sv
package z85_pkg;

    localparam int DIGITS      = 5;
    localparam int DIGIT_W     = 7;
    localparam int WORD_W      = 32;
    localparam int IDX_W       = $clog2(DIGITS);

    // floor(x / 85) == (x * RECIP_85) >> RECIP_SHIFT for every 32-bit x
    localparam logic [31:0] RECIP_85    = 32'd3233857729;
    localparam int          RECIP_SHIFT = 38;
    localparam int          QUOT_W      = 2 * WORD_W - RECIP_SHIFT;
    localparam logic [DIGIT_W-1:0] RADIX = 7'd85;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int ALPHA_LEN = 85;
    localparam logic [ALPHA_LEN*8-1:0] Z85_ALPHABET =
        "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

    typedef struct packed {
        logic              is_word;
        logic              bad;
        logic              last;
        logic [WORD_W-1:0] word;
    } z85_entry_t;

    // first character sits in the top byte of the packed literal
    function automatic logic [DIGIT_W-1:0] z85_char(input logic [DIGIT_W-1:0] digit);
        int pos;
        pos = ALPHA_LEN - 1 - int'(digit);
        if (pos < 0)
        begin
            pos = 0;
        end
        return Z85_ALPHABET[pos*8 +: DIGIT_W];
    endfunction

endpackage

>>> src/z85_front.sv
module z85_front #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                cmd,
    input  logic [7:0]          data_byte,
    input  logic [15:0]         message_length,
    output logic                push_valid,
    output z85_pkg::z85_entry_t push_entry
);

    logic                   active_reg, active_next;
    logic [1:0]             group_reg, group_next;
    logic [LENGTH_BITS-1:0] remain_reg, remain_next;
    logic [23:0]            acc_reg, acc_next;
    logic [LENGTH_BITS-1:0] len;
    logic                   accept;

    assign accept = in_valid && in_ready;
    assign len    = LENGTH_BITS'(message_length);

    always_comb
    begin
        active_next        = active_reg;
        group_next         = group_reg;
        remain_next        = remain_reg;
        acc_next           = acc_reg;
        push_valid         = 1'b0;
        push_entry.is_word = 1'b0;
        push_entry.bad     = 1'b0;
        push_entry.last    = 1'b1;
        push_entry.word    = {acc_reg, data_byte};
        if (accept)
        begin
            if (cmd == z85_pkg::CMD_START)
            begin
                // drop any message in progress
                active_next = 1'b0;
                group_next  = 2'd0;
                acc_next    = 24'd0;
                remain_next = '0;
                if (len[1:0] != 2'd0)
                begin
                    push_valid     = 1'b1;
                    push_entry.bad = 1'b1;
                end
                else if (len == '0)
                begin
                    push_valid = 1'b1;
                end
                else
                begin
                    remain_next = len;
                    active_next = 1'b1;
                end
            end
            else if (active_reg)
            begin
                group_next  = group_reg + 2'd1;
                remain_next = remain_reg - LENGTH_BITS'(1);
                acc_next    = {acc_reg[15:0], data_byte};
                if (group_reg == 2'd3)
                begin
                    push_valid         = 1'b1;
                    push_entry.is_word = 1'b1;
                    push_entry.last    = (remain_reg == LENGTH_BITS'(1));
                    acc_next           = 24'd0;
                    if (remain_reg == LENGTH_BITS'(1))
                    begin
                        active_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            group_reg  <= 2'd0;
            remain_reg <= '0;
            acc_reg    <= 24'd0;
        end
        else
        begin
            active_reg <= active_next;
            group_reg  <= group_next;
            remain_reg <= remain_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

>>> src/z85_queue.sv
module z85_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  z85_pkg::z85_entry_t push_entry,
    output logic                pop_valid,
    input  logic                pop_ready,
    output z85_pkg::z85_entry_t pop_entry
);

    z85_pkg::z85_entry_t           mem [z85_pkg::Q_DEPTH];
    logic [z85_pkg::Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [z85_pkg::Q_CNT_W-1:0]   count_reg;
    logic                          do_push, do_pop;

    assign push_ready = (count_reg != z85_pkg::Q_CNT_W'(z85_pkg::Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_entry  = mem[rd_ptr_reg];

    function automatic logic [z85_pkg::Q_PTR_W-1:0] wrap_inc(
        input logic [z85_pkg::Q_PTR_W-1:0] ptr);
        if (ptr == z85_pkg::Q_PTR_W'(z85_pkg::Q_DEPTH - 1))
        begin
            return '0;
        end
        return ptr + z85_pkg::Q_PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + z85_pkg::Q_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - z85_pkg::Q_CNT_W'(1);
            end
        end
    end

endmodule

>>> src/z85_back.sv
module z85_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  z85_pkg::z85_entry_t pop_entry,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [6:0]          out_char,
    output logic                is_char,
    output logic                bad_length,
    output logic                group_end,
    output logic                message_end
);

    localparam int DW = z85_pkg::DIGIT_W;
    localparam int IW = z85_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(z85_pkg::DIGITS - 1);

    // conversion stage: repeated divide by 85, registering the quotient and then storing the remainder for each digit
    logic                        conv_busy_reg;
    logic                        conv_word_reg, conv_bad_reg, conv_last_reg;
    logic [z85_pkg::WORD_W-1:0]  conv_val_reg;
    logic [z85_pkg::QUOT_W-1:0]  conv_prod_reg;
    logic                        conv_phase_reg;
    logic [IW-1:0]               conv_step_reg;
    logic [DW-1:0]               conv_digit_reg [z85_pkg::DIGITS];

    // emit stage: drives the result port
    logic                        emit_full_reg;
    logic                        emit_word_reg, emit_bad_reg, emit_last_reg;
    logic [IW-1:0]               emit_idx_reg;
    logic [DW-1:0]               emit_digit_reg [z85_pkg::DIGITS];

    logic                        conv_done, handoff, load, emit_free, out_xfer;
    logic [2*z85_pkg::WORD_W-1:0] product;
    logic [DW-1:0]               rem;
    logic [DW-1:0]               quot_lo;

    assign conv_done = (conv_step_reg == LAST_IDX);
    assign out_xfer  = out_valid && out_ready;
    assign emit_free = out_xfer && (!emit_word_reg || emit_idx_reg == LAST_IDX);
    assign handoff   = conv_busy_reg && conv_done && (!emit_full_reg || emit_free);
    assign pop_ready = !conv_busy_reg || handoff;
    assign load      = pop_valid && pop_ready;

    assign product = 64'(conv_val_reg) * 64'(z85_pkg::RECIP_85);
    assign quot_lo = conv_prod_reg[DW-1:0];
    // remainder is below 85, so seven low bits of the difference carry it
    assign rem     = conv_val_reg[DW-1:0] - DW'(quot_lo * z85_pkg::RADIX);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            conv_word_reg <= pop_entry.is_word;
            conv_bad_reg  <= pop_entry.bad;
            conv_last_reg <= pop_entry.last;
            conv_val_reg  <= pop_entry.word;
        end
        else if (conv_busy_reg && !conv_done)
        begin
            if (!conv_phase_reg)
            begin
                conv_prod_reg <= product[2*z85_pkg::WORD_W-1:z85_pkg::RECIP_SHIFT];
            end
            else
            begin
                conv_digit_reg[LAST_IDX - conv_step_reg] <= rem;
                conv_val_reg <= z85_pkg::WORD_W'(conv_prod_reg);
                // final quotient is the leading digit
                if (conv_step_reg == LAST_IDX - IW'(1))
                begin
                    conv_digit_reg[0] <= quot_lo;
                end
            end
        end
        if (handoff)
        begin
            emit_word_reg  <= conv_word_reg;
            emit_bad_reg   <= conv_bad_reg;
            emit_last_reg  <= conv_last_reg;
            emit_digit_reg <= conv_digit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_busy_reg  <= 1'b0;
            conv_phase_reg <= 1'b0;
            conv_step_reg  <= '0;
            emit_full_reg  <= 1'b0;
            emit_idx_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                conv_busy_reg  <= 1'b1;
                conv_phase_reg <= 1'b0;
                conv_step_reg  <= pop_entry.is_word ? '0 : LAST_IDX;
            end
            else if (handoff)
            begin
                conv_busy_reg <= 1'b0;
            end
            else if (conv_busy_reg && !conv_done)
            begin
                conv_phase_reg <= !conv_phase_reg;
                if (conv_phase_reg)
                begin
                    conv_step_reg <= conv_step_reg + IW'(1);
                end
            end

            if (handoff)
            begin
                emit_full_reg <= 1'b1;
                emit_idx_reg  <= '0;
            end
            else if (emit_free)
            begin
                emit_full_reg <= 1'b0;
            end
            else if (out_xfer)
            begin
                emit_idx_reg <= emit_idx_reg + IW'(1);
            end
        end
    end

    assign out_valid   = emit_full_reg;
    assign is_char     = emit_word_reg;
    assign out_char    = emit_word_reg ? z85_pkg::z85_char(emit_digit_reg[emit_idx_reg]) : '0;
    assign bad_length  = !emit_word_reg && emit_bad_reg;
    assign group_end   = emit_word_reg && (emit_idx_reg == LAST_IDX);
    assign message_end = emit_word_reg ? (emit_last_reg && emit_idx_reg == LAST_IDX) : 1'b1;

endmodule

>>> src/z85_stream_encoder_core.sv
// Z85 stream encoder core.
// Path: an entry goes from the queue to the conversion stage, then on to the emit stage;
// a status result needs no divide steps, a word needs four divide-by-85 steps, each of
// which registers the quotient and then stores the remainder. A new word loads as the
// last one hands off once the emit stage is free, overlapped with character transfers.
// Reset: rst_n clears all control state asynchronously; the block comes up idle and empty.
module z85_stream_encoder_core #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  data_byte,
    input  logic [15:0] message_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  out_char,
    output logic        is_char,
    output logic        bad_length,
    output logic        group_end,
    output logic        message_end
);

    logic                push_valid, push_ready;
    z85_pkg::z85_entry_t push_entry;
    logic                pop_valid, pop_ready;
    z85_pkg::z85_entry_t pop_entry;

    assign in_ready = push_ready;

    z85_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .data_byte     (data_byte),
        .message_length(message_length),
        .push_valid    (push_valid),
        .push_entry    (push_entry)
    );

    z85_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_entry(push_entry),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry)
    );

    z85_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .is_char    (is_char),
        .bad_length (bad_length),
        .group_end  (group_end),
        .message_end(message_end)
    );

endmodule

>>> src/z85_checker.sv
module z85_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] out_char,
    input logic       is_char,
    input logic       bad_length,
    input logic       group_end,
    input logic       message_end
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(is_char)
            && $stable(bad_length) && $stable(group_end) && $stable(message_end))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_char |-> message_end && !group_end && out_char == 7'd0)
        else $error("malformed status result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_char && message_end |-> group_end && !bad_length)
        else $error("message ended inside a group");

    // after a character that is not the fifth of its group, the next result is a character
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && is_char && !group_end ##1 out_valid |-> is_char)
        else $error("group cut short");

endmodule

bind z85_stream_encoder_core z85_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .is_char    (is_char),
    .bad_length (bad_length),
    .group_end  (group_end),
    .message_end(message_end)
);
